[rtl/satq_pkg.sv]
// Package for the sorted alarm timer queue.
// Holds the entry payload type, the cell command type and the controller states.
// No dependencies.
package satq_pkg;

  localparam int unsigned FIELD_BITS = 16;

  // Payload carried by one queue entry next to its deadline.
  typedef struct packed {
    logic [FIELD_BITS-1:0] delay;
    logic [FIELD_BITS-1:0] tag;
  } payload_t;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic ins;  // place the new entry in sorted position
    logic pop;  // remove the head, everything moves one cell toward the head
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } satq_state_e;

  // Result kinds reported on the output.
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_DROPPED = 1'b1;

  // Input operation codes.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

endpackage

[rtl/satq_cell.sv]
// One cell of the sorted timer queue chain: a valid bit, a deadline and a payload.
// Depends on satq_pkg for the payload and command types.
module satq_cell #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  satq_pkg::cell_cmd_t  cmd_i,
  input  logic [TIME_BITS-1:0] new_deadline_i,
  input  satq_pkg::payload_t   new_payload_i,
  input  logic                 left_valid_i,
  input  logic                 left_keep_i,
  input  logic [TIME_BITS-1:0] left_deadline_i,
  input  satq_pkg::payload_t   left_payload_i,
  input  logic                 right_valid_i,
  input  logic [TIME_BITS-1:0] right_deadline_i,
  input  satq_pkg::payload_t   right_payload_i,
  output logic                 valid_o,
  output logic                 keep_o,
  output logic [TIME_BITS-1:0] deadline_o,
  output satq_pkg::payload_t   payload_o
);
  import satq_pkg::*;

  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  payload_t             payload_q, payload_d;

  // An entry stays in place when it is strictly earlier than the new one.
  assign keep_o = valid_q && (deadline_q < new_deadline_i);

  always_comb begin
    valid_d    = valid_q;
    deadline_d = deadline_q;
    payload_d  = payload_q;
    if (cmd_i.ins && !keep_o) begin
      if (left_keep_i) begin
        valid_d    = 1'b1;
        deadline_d = new_deadline_i;
        payload_d  = new_payload_i;
      end else begin
        valid_d    = left_valid_i;
        deadline_d = left_deadline_i;
        payload_d  = left_payload_i;
      end
    end else if (cmd_i.pop) begin
      valid_d    = right_valid_i;
      deadline_d = right_deadline_i;
      payload_d  = right_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    payload_q  <= payload_d;
  end

  assign valid_o    = valid_q;
  assign deadline_o = deadline_q;
  assign payload_o  = payload_q;

endmodule

[rtl/sorted_alarm_timer_queue.sv]
// Top level of the sorted alarm timer queue: time counter, drain controller,
// result register and the chain of satq_cell instances.
// Depends on satq_pkg and satq_cell.
//
// The queue keeps up to QUEUE_DEPTH pending alarms sorted by deadline in a row
// of cells, the head in cell 0. An item is taken when start is high while busy
// is low. A tick advances the saturating time counter by one; an insert places
// the alarm at time plus delay, ahead of every entry with an equal or later
// deadline, in the cycle of the transfer, with every later entry moving one
// cell in the same cycle. After the transfer the block is busy and checks the
// head once per cycle: each expired head is removed, the whole chain moving
// one cell toward the head, and reported. No new item is taken until the drain
// finds no further expired head. Results come from a register in the cycle
// after the step that produced them, each on result_valid_o for exactly one
// cycle; the receiver cannot stall and must take every transfer. The last
// result of an item carries last_in_run_o and may appear in the cycle in which
// the next item is already taken. An insert into a full queue is dropped and
// reported with report_kind_o high; it is then the only result.
module sorted_alarm_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [15:0] delay_ticks_i,
  input  logic [15:0] alarm_tag_i,
  output logic        result_valid_o,
  output logic [15:0] fired_delay_o,
  output logic [15:0] fired_tag_o,
  output logic        report_kind_o,
  output logic        last_in_run_o
);
  import satq_pkg::*;

  satq_state_e          state_q, state_d;
  logic [TIME_BITS-1:0] time_q, time_d;

  logic                 strobe_q, strobe_d;
  payload_t             out_pay_q, out_pay_d;
  logic                 kind_q, kind_d;
  logic                 last_q, last_d;

  logic                   accept;
  logic                   full;
  logic [TIME_BITS:0]     dl_sum;
  logic [TIME_BITS-1:0]   new_deadline;
  payload_t               new_payload;
  cell_cmd_t              cmd;
  logic                   head_exp;
  logic                   next_exp;

  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_keep;
  logic [TIME_BITS-1:0]   cell_dl  [QUEUE_DEPTH];
  payload_t               cell_pay [QUEUE_DEPTH];

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_DRAIN);
  assign full   = cell_valid[QUEUE_DEPTH-1];

  // Saturating deadline: time plus delay, clamped at the top of the time range.
  assign dl_sum       = {1'b0, time_q} + (TIME_BITS+1)'(delay_ticks_i);
  assign new_deadline = dl_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dl_sum[TIME_BITS-1:0];
  assign new_payload  = '{delay: delay_ticks_i, tag: alarm_tag_i};

  // Only the two front cells are compared against the time: the head decides
  // whether to pop, the second cell whether this pop ends the run.
  assign head_exp = cell_valid[0] && (cell_dl[0] <= time_q);
  assign next_exp = cell_valid[1] && (cell_dl[1] <= time_q);

  always_comb begin
    state_d   = state_q;
    time_d    = time_q;
    strobe_d  = 1'b0;
    out_pay_d = out_pay_q;
    kind_d    = kind_q;
    last_d    = last_q;
    cmd       = '{ins: 1'b0, pop: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DRAIN;
          if (opcode_i == OP_TICK) begin
            if (time_q != {TIME_BITS{1'b1}}) begin
              time_d = time_q + TIME_BITS'(1);
            end
          end else if (full) begin
            // A full queue holds no expired entry, so the drop stands alone.
            strobe_d  = 1'b1;
            out_pay_d = new_payload;
            kind_d    = KIND_DROPPED;
            last_d    = 1'b1;
          end else begin
            cmd.ins = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (head_exp) begin
          cmd.pop   = 1'b1;
          strobe_d  = 1'b1;
          out_pay_d = cell_pay[0];
          kind_d    = KIND_EXPIRED;
          last_d    = !next_exp;
          if (!next_exp) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      time_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      time_q   <= time_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pay_q <= out_pay_d;
    kind_q    <= kind_d;
    last_q    <= last_d;
  end

  assign result_valid_o = strobe_q;
  assign fired_delay_o  = out_pay_q.delay;
  assign fired_tag_o    = out_pay_q.tag;
  assign report_kind_o  = kind_q;
  assign last_in_run_o  = last_q;

  // The chain. Cell 0 sees a left neighbor that always keeps, so it takes the
  // new entry whenever its own entry does not stay; the last cell sees an
  // empty right neighbor, so a pop empties it.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 l_valid;
    logic                 l_keep;
    logic [TIME_BITS-1:0] l_dl;
    payload_t             l_pay;
    logic                 r_valid;
    logic [TIME_BITS-1:0] r_dl;
    payload_t             r_pay;

    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_keep  = 1'b1;
      assign l_dl    = cell_dl[i];
      assign l_pay   = cell_pay[i];
    end else begin : g_inner_l
      assign l_valid = cell_valid[i-1];
      assign l_keep  = cell_keep[i-1];
      assign l_dl    = cell_dl[i-1];
      assign l_pay   = cell_pay[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_last
      assign r_valid = 1'b0;
      assign r_dl    = cell_dl[i];
      assign r_pay   = cell_pay[i];
    end else begin : g_inner_r
      assign r_valid = cell_valid[i+1];
      assign r_dl    = cell_dl[i+1];
      assign r_pay   = cell_pay[i+1];
    end

    satq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .cmd_i           (cmd),
      .new_deadline_i  (new_deadline),
      .new_payload_i   (new_payload),
      .left_valid_i    (l_valid),
      .left_keep_i     (l_keep),
      .left_deadline_i (l_dl),
      .left_payload_i  (l_pay),
      .right_valid_i   (r_valid),
      .right_deadline_i(r_dl),
      .right_payload_i (r_pay),
      .valid_o         (cell_valid[i]),
      .keep_o          (cell_keep[i]),
      .deadline_o      (cell_dl[i]),
      .payload_o       (cell_pay[i])
    );
  end

  // Occupied cells always form an unbroken run starting at the head.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + QUEUE_DEPTH'(1))) == '0)
    else $error("queue cells are not a contiguous run from the head");

  // The two front entries are in deadline order.
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> (cell_dl[0] <= cell_dl[1]))
    else $error("head entries out of deadline order");

  // A dropped insert is always the single and final result of its item; this checks that it is marked last.
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && report_kind_o == KIND_DROPPED) |-> last_in_run_o)
    else $error("dropped insert report not marked last");

  // Every accepted item is followed by at least one drain check.
  a_accept_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not enter the drain step");

  // A result that does not close its run comes while the drain is still running.
  a_pop_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_in_run_o) |-> busy)
    else $error("non-final result while controller idle");

endmodule

[tb/sv/sorted_alarm_timer_queue_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_alarm_timer_queue: a directed opening followed by random
// ticks and inserts, with every result checked against a predictor kept in a small ledger class.
// Depends on satq_pkg and on the sorted_alarm_timer_queue RTL.
module sorted_alarm_timer_queue_tb;
  import satq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 300;
  // No legal run comes this close to the limit without a transfer on either side: the longest
  // sender gap plus a full drain of the queue stays below it.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last expected result, so that a stray late result is still seen.
  localparam int unsigned DRAIN_SLACK = 24;
  localparam int unsigned MAX_REPORTED = 10;

  // One reported alarm or dropped insert, in the order of the result ports.
  typedef struct packed {
    logic [15:0] delay;
    logic [15:0] tag;
    logic        kind;
    logic        last;
  } alarm_report_t;

  // The ledger predicts the queue: it keeps its own time counter and its own sorted copy of the
  // pending alarms, and holds the results each accepted item is due to produce.
  class alarm_ledger;
    logic [31:0]   tick_count;
    logic [31:0]   due_at [QUEUE_DEPTH];
    logic [15:0]   due_delay [QUEUE_DEPTH];
    logic [15:0]   due_tag [QUEUE_DEPTH];
    int unsigned   pending;
    alarm_report_t due_reports [$];
    int unsigned   fault_count;

    function new();
      tick_count  = '0;
      pending     = 0;
      fault_count = 0;
    endfunction

    function string describe(alarm_report_t rep);
      return $sformatf("delay=%h tag=%h kind=%b last=%b", rep.delay, rep.tag, rep.kind,
                       rep.last);
    endfunction

    function void flag_fault(string why);
      fault_count++;
      if (fault_count <= MAX_REPORTED) begin
        $display("[%0t] mismatch: %s", $realtime, why);
      end
    endfunction

    // Called on every accepted transfer on the command side.
    function void book_request(logic op, logic [15:0] delay, logic [15:0] tag);
      logic [31:0]   deadline;
      int unsigned   slot;
      int unsigned   fired;
      int unsigned   made;
      alarm_report_t rep;
      made = 0;
      if (op == OP_TICK) begin
        if (tick_count != '1) begin
          tick_count = tick_count + 32'd1;
        end
      end else begin
        // The deadline saturates instead of wrapping, so sorting stays correct near the top.
        if (32'hFFFF_FFFF - tick_count < 32'(delay)) begin
          deadline = '1;
        end else begin
          deadline = tick_count + 32'(delay);
        end
        if (pending >= QUEUE_DEPTH) begin
          rep = '{delay: delay, tag: tag, kind: KIND_DROPPED, last: 1'b0};
          due_reports.push_back(rep);
          made++;
        end else begin
          // The new alarm goes ahead of the first entry with an equal or later deadline.
          slot = 0;
          while (slot < pending && due_at[slot] < deadline) begin
            slot++;
          end
          for (int i = pending; i > slot; i--) begin
            due_at[i]    = due_at[i-1];
            due_delay[i] = due_delay[i-1];
            due_tag[i]   = due_tag[i-1];
          end
          due_at[slot]    = deadline;
          due_delay[slot] = delay;
          due_tag[slot]   = tag;
          pending++;
        end
      end
      // Every expired entry leaves from the head, in queue order.
      fired = 0;
      while (fired < pending && due_at[fired] <= tick_count && made < QUEUE_DEPTH) begin
        rep = '{delay: due_delay[fired], tag: due_tag[fired], kind: KIND_EXPIRED, last: 1'b0};
        due_reports.push_back(rep);
        made++;
        fired++;
      end
      if (fired > 0) begin
        for (int i = fired; i < pending; i++) begin
          due_at[i-fired]    = due_at[i];
          due_delay[i-fired] = due_delay[i];
          due_tag[i-fired]   = due_tag[i];
        end
        pending = pending - fired;
      end
      if (made > 0) begin
        rep = due_reports.pop_back();
        rep.last = 1'b1;
        due_reports.push_back(rep);
      end
    endfunction

    // Called on every result transfer; compares it with the oldest expectation.
    function void check_report(alarm_report_t got);
      alarm_report_t want;
      if (due_reports.size() == 0) begin
        flag_fault({"result with nothing expected: ", describe(got)});
        return;
      end
      want = due_reports.pop_front();
      if (want !== got) begin
        flag_fault({"expected ", describe(want), ", got ", describe(got)});
      end
    endfunction

    function void close_out();
      if (due_reports.size() != 0) begin
        flag_fault($sformatf("%0d expected results never arrived, oldest %s",
                             due_reports.size(), describe(due_reports[0])));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode_i = OP_TICK;
  logic [15:0] delay_ticks_i = '0;
  logic [15:0] alarm_tag_i = '0;
  logic        result_valid_o;
  logic [15:0] fired_delay_o;
  logic [15:0] fired_tag_o;
  logic        report_kind_o;
  logic        last_in_run_o;

  alarm_ledger   ledger = new();
  bit            steady_sender = 1'b0;
  int unsigned   quiet_cycles = 0;
  alarm_report_t seen;

  sorted_alarm_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (32)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .delay_ticks_i (delay_ticks_i),
    .alarm_tag_i   (alarm_tag_i),
    .result_valid_o(result_valid_o),
    .fired_delay_o (fired_delay_o),
    .fired_tag_o   (fired_tag_o),
    .report_kind_o (report_kind_o),
    .last_in_run_o (last_in_run_o)
  );

  always #2 clk_i = ~clk_i;

  // Results cannot be held off, so every cycle with the strobe high is a transfer. All outputs
  // change on nonblocking updates, so reading them right at the edge sees the settled values.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      seen = {fired_delay_o, fired_tag_o, report_kind_o, last_in_run_o};
      ledger.check_report(seen);
    end
  end

  // The watchdog restarts on any transfer, on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || result_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly back to back or short gaps, now and then a long one. During a steady stretch the
  // sender never idles, so items arrive the cycle the block frees up.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_sender || roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Short delays keep alarms expiring often; a few full-range delays exercise every bit and
  // park entries that never expire, which pushes the queue toward full.
  function automatic logic [15:0] pick_delay();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      return 16'($urandom);
    end else if (roll < 12) begin
      return '0;
    end
    return 16'($urandom_range(1, 12));
  endfunction

  // The sender lowers start only for a gap, never in the step where it raises it again.
  task automatic pause_sender(input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Presents one item and holds it until the block takes the transfer.
  task automatic issue_item(input logic op, input logic [15:0] delay, input logic [15:0] tag);
    start         <= 1'b1;
    opcode_i      <= op;
    delay_ticks_i <= delay;
    alarm_tag_i   <= tag;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    ledger.book_request(op, delay, tag);
    pause_sender(pick_gap());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A tick on an empty queue gives no result at all.
    issue_item(OP_TICK, 16'hFFFF, 16'hFFFF);
    // A zero delay expires in the same item that inserts it.
    issue_item(OP_INSERT, 16'h0000, 16'hFFFF);
    // The longest delay parks an entry that stays in the queue for the rest of the run.
    issue_item(OP_INSERT, 16'hFFFF, 16'h0000);
    // Fill the queue with short delays; repeated deadlines check that the newest of equal
    // deadlines goes first.
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      issue_item(OP_INSERT, 16'(i % 3 + 1), 16'(16'hA500 + i));
    end
    // Full queue: the insert is dropped and reported on its own.
    issue_item(OP_INSERT, 16'h5555, 16'hAAAA);
    // Each tick now expires several entries in a single run.
    repeat (3) issue_item(OP_TICK, 16'h0000, 16'h0000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) begin
        steady_sender = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 1) == 1) begin
        issue_item(OP_INSERT, pick_delay(), 16'($urandom));
      end else begin
        // A tick ignores its payload; random values still toggle every input bit.
        issue_item(OP_TICK, 16'($urandom), 16'($urandom));
      end
    end
    start <= 1'b0;

    while (ledger.due_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_SLACK) @(posedge clk_i);
    ledger.close_out();
    if (ledger.fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/satq_pkg.sv
rtl/satq_cell.sv
rtl/sorted_alarm_timer_queue.sv
tb/sv/sorted_alarm_timer_queue_tb.sv
